// ===== rtl/gsm_pkg.sv =====
// Types and constants shared by the 3x3 binomial grid smoother and its checker.
// No dependencies.
package gsm_pkg;

  localparam int SAMPLE_W = 16;          // signed Q8.8 height
  localparam int COORD_W  = 8;           // reported row/column width
  localparam int CFG_W    = 9;           // grid_size register width
  localparam int SUM_W    = SAMPLE_W + 4;
  localparam int COL_W    = SAMPLE_W + 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] height_sample;
    logic                       frame_start;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_height;
    logic [COORD_W-1:0]         out_row;
    logic [COORD_W-1:0]         out_col;
    logic                       last_of_grid;
  } result_t;

endpackage

// ===== rtl/gaussian_3x3_grid_smoother_core.sv =====
// Top level of the 3x3 binomial grid smoother: line memory, window and output register.
// Depends on gsm_pkg.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+---------------------
//  sample   | in        | sample_valid / sample_ready    | gsm_pkg::sample_t
//  result   | out       | result_valid / result_ready    | gsm_pkg::result_t
//  config   | in        | cfg_we (no wait)               | cfg_wdata (grid_size)
//
// One sample is taken per cycle unless a stalled result holds the window stage. The
// line memory read lands in the window stage with the transferred sample; when that
// sample completes a window, the kernel sum is registered into the output register
// along with the write-back. Reset is synchronous and needs no clearing pass: line
// entries feed a result only after being written; a stalled result drops sample_ready.
module gaussian_3x3_grid_smoother_core #(
  parameter int GRID_MAX = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  gsm_pkg::sample_t            sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output gsm_pkg::result_t            result,
  input  logic                        cfg_we,
  input  logic [gsm_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int SW    = gsm_pkg::SAMPLE_W;
  localparam int CW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW    = $clog2(GRID_MAX + 1);
  localparam int N_RST = (GRID_MAX < 256) ? GRID_MAX : 256;

  // Effective grid side, clamped when written.
  logic [NW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff <= NW'(N_RST);
    end else if (cfg_we) begin
      if (cfg_wdata < gsm_pkg::CFG_W'(3)) begin
        n_eff <= NW'(3);
      end else if (32'(cfg_wdata) > GRID_MAX) begin
        n_eff <= NW'(GRID_MAX);
      end else begin
        n_eff <= NW'(cfg_wdata);
      end
    end
  end

  // ---------------- position counters (transfer stage) ----------------
  logic [CW-1:0] row_cnt, col_cnt;
  logic [CW-1:0] row_next, col_next;
  logic [NW-1:0] r_pre, c_pre, r_cur, c_cur, r_inc, c_inc;
  logic [CW-1:0] r_pos, c_pos;
  logic          take;

  assign take = sample_valid && sample_ready;

  always_comb begin
    r_pre = sample.frame_start ? '0 : NW'(row_cnt);
    c_pre = sample.frame_start ? '0 : NW'(col_cnt);
    r_cur = r_pre;
    c_cur = c_pre;
    if (c_pre >= n_eff) begin
      c_cur = '0;
      r_cur = r_pre + NW'(1);
    end
    if (r_cur >= n_eff) begin
      r_cur = '0;
    end
    r_pos = CW'(r_cur);
    c_pos = CW'(c_cur);
    c_inc = c_cur + NW'(1);
    r_inc = r_cur + NW'(1);
    col_next = CW'(c_inc);
    row_next = r_pos;
    if (c_inc >= n_eff) begin
      col_next = '0;
      row_next = (r_inc >= n_eff) ? '0 : CW'(r_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (take) begin
      row_cnt <= row_next;
      col_cnt <= col_next;
    end
  end

  // ---------------- window stage registers ----------------
  logic                 s1_valid;
  logic                 s1_emit, s1_last;
  logic signed [SW-1:0] s1_x;
  logic [CW-1:0]        s1_col, s1_rm1, s1_cm1;
  logic                 s1_go;

  assign s1_go        = s1_valid && (!s1_emit || !result_valid || result_ready);
  assign sample_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x    <= sample.height_sample;
      s1_col  <= c_pos;
      s1_rm1  <= r_pos - CW'(1);
      s1_cm1  <= c_pos - CW'(1);
      s1_emit <= (r_cur >= NW'(2)) && (c_cur >= NW'(2));
      s1_last <= (r_cur == n_eff - NW'(1)) && (c_cur == n_eff - NW'(1));
    end
  end

  // ---------------- line memory: {upper, middle} per column ----------------
  logic [2*SW-1:0] line_mem [GRID_MAX];
  logic [2*SW-1:0] rd_q, fwd_q, line_eff, line_wr;
  logic            fwd_sel;

  assign line_eff = fwd_sel ? fwd_q : rd_q;
  // The old middle row moves up; the new sample becomes the middle row.
  assign line_wr  = {line_eff[SW-1:0], s1_x};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col] <= line_wr;
    end
    if (take) begin
      rd_q <= line_mem[c_pos];
    end
  end

  // A read of the column being written in the same cycle sees the old entry,
  // so the written value is forwarded instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (take) begin
      fwd_sel <= s1_go && (s1_col == c_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_q <= line_wr;
    end
  end

  // ---------------- 3x3 window and kernel ----------------
  // Two stored columns (oldest dropped); index 0 upper row, 2 current row.
  logic signed [SW-1:0]              win_a [3];
  logic signed [SW-1:0]              win_b [3];
  logic signed [SW-1:0]              new_up, new_mid;
  logic signed [gsm_pkg::COL_W-1:0]  cs0, cs1, cs2;
  logic signed [gsm_pkg::SUM_W-1:0]  total;

  assign new_up  = line_eff[2*SW-1:SW];
  assign new_mid = line_eff[SW-1:0];

  function automatic logic signed [gsm_pkg::COL_W-1:0] col_sum(
    input logic signed [SW-1:0] a,
    input logic signed [SW-1:0] b,
    input logic signed [SW-1:0] c
  );
    col_sum = gsm_pkg::COL_W'(a) + (gsm_pkg::COL_W'(b) <<< 1) + gsm_pkg::COL_W'(c);
  endfunction

  assign cs0   = col_sum(win_a[0], win_a[1], win_a[2]);
  assign cs1   = col_sum(win_b[0], win_b[1], win_b[2]);
  assign cs2   = col_sum(new_up, new_mid, s1_x);
  assign total = gsm_pkg::SUM_W'(cs0) + (gsm_pkg::SUM_W'(cs1) <<< 1) + gsm_pkg::SUM_W'(cs2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        win_a[k] <= '0;
        win_b[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 3; k++) begin
        win_a[k] <= win_b[k];
      end
      win_b[0] <= new_up;
      win_b[1] <= new_mid;
      win_b[2] <= s1_x;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Arithmetic shift gives the floor of the division by 16.
  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      result.smoothed_height <= SW'(total >>> 4);
      result.out_row         <= gsm_pkg::COORD_W'(s1_rm1);
      result.out_col         <= gsm_pkg::COORD_W'(s1_cm1);
      result.last_of_grid    <= s1_last;
    end
  end

endmodule

// ===== rtl/gsm_checker.sv =====
// Port-level checks for the grid smoother, attached to the top level by bind.
// Depends on gsm_pkg and gaussian_3x3_grid_smoother_core.
module gsm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_valid,
  input logic                      sample_ready,
  input gsm_pkg::sample_t          sample,
  input logic                      result_valid,
  input logic                      result_ready,
  input gsm_pkg::result_t          result
);

  // A result that is not taken stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A sample that is offered but not taken stays offered and unchanged.
  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("sample changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // The last interior sample sits on the diagonal.
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_grid |-> result.out_row == result.out_col)
    else $error("last_of_grid off the diagonal");

  // With no result pending the window stage can always drain, so samples flow.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample_ready low with empty output");

endmodule

bind gaussian_3x3_grid_smoother_core gsm_checker u_gsm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== tb/sv/gsm_smoothing_checker.sv =====
// Checker for the 3x3 binomial grid smoother: tracks grid position, line rows and the
// window from observed sample transfers and compares every result transfer in order.
// Depends on gsm_pkg.
module gsm_smoothing_checker #(
  parameter int GRID_MAX = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  input  logic                      sample_ready,
  input  gsm_pkg::sample_t          sample,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  gsm_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [gsm_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  logic [gsm_pkg::CFG_W-1:0]           grid_size_reg;
  logic signed [gsm_pkg::SAMPLE_W-1:0] row_older [GRID_MAX];
  logic signed [gsm_pkg::SAMPLE_W-1:0] row_newer [GRID_MAX];
  logic signed [gsm_pkg::SAMPLE_W-1:0] win [9];
  int                                  row_pos;
  int                                  col_pos;
  gsm_pkg::result_t                    smoothed_q [$];
  gsm_pkg::result_t                    want;

  // Advances the grid position by one sample and queues the smoothed value of the
  // interior sample whose window it completes.
  task automatic smooth_sample(input gsm_pkg::sample_t s);
    int side;
    int r;
    int c;
    int acc;
    gsm_pkg::result_t res;
    side = grid_size_reg;
    if (side < 3) side = 3;
    if (side > GRID_MAX) side = GRID_MAX;
    if (s.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= side) row_pos = 0;
    r = row_pos;
    c = col_pos;
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = row_older[c];
    win[5] = row_newer[c];
    win[8] = s.height_sample;
    row_older[c] = row_newer[c];
    row_newer[c] = s.height_sample;
    col_pos = c + 1;
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= side) row_pos = 0;
    end
    if (r >= 2 && c >= 2) begin
      acc = win[0] + 2*win[1] + win[2]
          + 2*win[3] + 4*win[4] + 2*win[5]
          + win[6] + 2*win[7] + win[8];
      // An arithmetic shift of the signed sum rounds toward minus infinity.
      res.smoothed_height = gsm_pkg::SAMPLE_W'(acc >>> 4);
      res.out_row         = gsm_pkg::COORD_W'(r - 1);
      res.out_col         = gsm_pkg::COORD_W'(c - 1);
      res.last_of_grid    = (r == side - 1) && (c == side - 1);
      smoothed_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      grid_size_reg = 9'd256;
      row_pos = 0;
      col_pos = 0;
      for (int i = 0; i < GRID_MAX; i++) begin
        row_older[i] = '0;
        row_newer[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      smoothed_q.delete();
    end else begin
      // Results go first so that a result can never match a sample of the same edge.
      if (result_valid && result_ready) begin
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected result h=%0d row=%0d col=%0d last=%0b", $time,
                   result.smoothed_height, result.out_row, result.out_col,
                   result.last_of_grid);
          fail_count++;
        end else begin
          want = smoothed_q.pop_front();
          if (result !== want) begin
            $display("%0t: expected h=%0d r=%0d c=%0d l=%0b, got h=%0d r=%0d c=%0d l=%0b",
                     $time, want.smoothed_height, want.out_row, want.out_col,
                     want.last_of_grid, result.smoothed_height, result.out_row,
                     result.out_col, result.last_of_grid);
            fail_count++;
          end
        end
      end
      if (cfg_we) grid_size_reg = cfg_wdata;
      if (sample_valid && sample_ready) smooth_sample(sample);
    end
    pending = smoothed_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the grid smoother testbench: clock, reset, sample and result stimulus,
// grid size changes and the verdict. Depends on gsm_pkg, the smoother core and
// gsm_smoothing_checker.
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_ITEMS = 1950;
  localparam int PHASE_MAX = 300;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_ready;
  gsm_pkg::sample_t          sample = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  gsm_pkg::result_t          result;
  logic                      cfg_we = 1'b0;
  logic [gsm_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;
  int cur_side = 256;
  int grid_pos = 0;
  bit force_start = 1'b0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gaussian_3x3_grid_smoother_core uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  gsm_smoothing_checker chk (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int held;
    bit hold_done;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        result_ready = 1'b0;
        for (held = 0; held < 300; held++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        result_ready = steady || ($urandom_range(99) >= 31);
        @(negedge clk);
      end
    end
  end

  function automatic int side_of(input int v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic logic signed [gsm_pkg::SAMPLE_W-1:0] random_height();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if (pick < 40) return gsm_pkg::SAMPLE_W'(int'($urandom_range(16)) - 8);
    return gsm_pkg::SAMPLE_W'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [gsm_pkg::SAMPLE_W-1:0] h, input bit fs);
    while (!steady && $urandom_range(99) < 31) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    if (force_start) fs = 1'b1;
    force_start = 1'b0;
    sample_valid = 1'b1;
    sample.height_sample = h;
    sample.frame_start = fs;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
    if (fs) grid_pos = 0;
    grid_pos++;
    if (grid_pos >= cur_side * cur_side) grid_pos = 0;
    sent++;
  endtask

  task automatic drain_results();
    sample_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // The grid size is only changed with no result outstanding and the pipeline empty.
  // A larger grid would read line entries never written, so it restarts the grid.
  task automatic write_grid_size(input int v);
    int new_side;
    drain_results();
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = gsm_pkg::CFG_W'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    new_side = side_of(v);
    if (new_side > cur_side) force_start = 1'b1;
    cur_side = new_side;
    grid_pos = grid_pos % (cur_side * cur_side);
  endtask

  initial begin
    int phase;
    int count;
    int pick;
    int cfg_val;
    bit fs;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Smallest grid: full-scale positive, a wrap into a new grid with a lone -1 at
    // the center (the shifted sum rounds down), then full-scale negative.
    write_grid_size(3);
    for (int i = 0; i < 9; i++) send_sample(16'sh7fff, i == 0);
    for (int i = 0; i < 9; i++) send_sample((i == 4) ? -16'sd1 : 16'sd0, 1'b0);
    for (int i = 0; i < 9; i++) send_sample(16'sh8000, i == 0);

    // Largest grid, then a shrink early in the fourth row.
    write_grid_size(511);
    for (int i = 0; i < 3 * 256 + 20; i++) send_sample(random_height(), 1'b0);
    write_grid_size(10);
    for (int i = 0; i < 150; i++) send_sample(random_height(), 1'b0);

    phase = 0;
    while (sent < TARGET_ITEMS) begin
      steady = (phase == 2);
      pick = $urandom_range(99);
      if (pick < 70)      cfg_val = $urandom_range(12, 3);
      else if (pick < 80) cfg_val = $urandom_range(2, 0);
      else if (pick < 95) cfg_val = $urandom_range(40, 13);
      else                cfg_val = $urandom_range(1) ? 257 : 256;
      // The long hold-off needs a small grid so that results pile up behind it.
      if (phase == 1) cfg_val = $urandom_range(12, 8);
      write_grid_size(cfg_val);
      if (cur_side > 40) count = 3 * cur_side + $urandom_range(cur_side);
      else count = cur_side * cur_side * $urandom_range(3, 1) + $urandom_range(cur_side);
      if (steady && count < 150) count = 150;
      if (count > PHASE_MAX) count = PHASE_MAX;
      if (phase > 2 && count > TARGET_ITEMS - sent) count = TARGET_ITEMS - sent;
      if (phase == 1) hold_req = 1'b1;
      for (int k = 0; k < count; k++) begin
        if (k == count / 2) begin
          pick = $urandom_range(99);
          if (phase == 1 || pick < 25) drain_results();
          else if (pick < 55) write_grid_size($urandom_range(cfg_val));
        end
        fs = 1'b0;
        if (grid_pos == 0) fs = ($urandom_range(99) < 80);
        else if ($urandom_range(99) < 2) fs = 1'b1;
        send_sample(random_height(), fs);
      end
      phase++;
    end
    steady = 1'b0;

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== gaussian_3x3_grid_smoother_core.f =====
rtl/gsm_pkg.sv
rtl/gaussian_3x3_grid_smoother_core.sv
rtl/gsm_checker.sv
tb/sv/gsm_smoothing_checker.sv
tb/sv/testbench.sv
